// File: rtl/core/swk_pkg.sv
// swk_pkg: shared widths, constants, cordic arctangent table and item structs
// for the swerve wheel kinematics block; used by swk_cordic_cell and swerve_wheel_kinematics
`default_nettype none

package swk_pkg;

  // cordic step count default and table depth
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 24;

  // datapath widths
  localparam int RW  = 28;  // rotation x/y (q.22 plus growth)
  localparam int RZW = 26;  // rotation angle accumulator, deg * 2^16
  localparam int TW  = 25;  // turn terms
  localparam int GW  = 26;  // gain compensated rotation result
  localparam int PW  = 27;  // swerve terms a, b, c, d
  localparam int VW  = 30;  // vectoring x/y
  localparam int VZW = 27;  // vectoring angle accumulator
  localparam int SW  = 20;  // rounded speed before scaling
  localparam int ATW = 23;  // arctangent table entries

  localparam logic [15:0] INV_GAIN  = 16'd39797;
  localparam logic [15:0] RATIO_RST = 16'd46341;

  localparam logic signed [17:0] HEAD_HALF    = 18'sd23040;
  localparam logic signed [17:0] HEAD_QUARTER = 18'sd11520;
  localparam logic signed [17:0] HEAD_TURN    = 18'sd46080;

  localparam logic signed [VZW-1:0] Z_HALF_TURN = 27'sd11796480;
  localparam logic signed [18:0]    ANG_MAX     = 19'sd23040;
  localparam logic signed [21:0]    SPEED_MAX   = 22'sd32767;

  // register indexes
  localparam logic [2:0] REG_LENGTH_RATIO = 3'd0;
  localparam logic [2:0] REG_WIDTH_RATIO  = 3'd1;
  localparam logic [2:0] REG_X_DEADBAND   = 3'd2;
  localparam logic [2:0] REG_Y_DEADBAND   = 3'd3;
  localparam logic [2:0] REG_TURN_POS_DB  = 3'd4;
  localparam logic [2:0] REG_TURN_NEG_DB  = 3'd5;

  // atan(2^-i) in degrees * 2^16
  function automatic logic [ATW-1:0] atan_deg16(input int i);
    logic [ATW-1:0] v;
    case (i)
      0:  v = 23'd2949120;
      1:  v = 23'd1740967;
      2:  v = 23'd919879;
      3:  v = 23'd466945;
      4:  v = 23'd234379;
      5:  v = 23'd117304;
      6:  v = 23'd58666;
      7:  v = 23'd29335;
      8:  v = 23'd14668;
      9:  v = 23'd7334;
      10: v = 23'd3667;
      11: v = 23'd1833;
      12: v = 23'd917;
      13: v = 23'd458;
      14: v = 23'd229;
      15: v = 23'd115;
      16: v = 23'd57;
      17: v = 23'd29;
      18: v = 23'd14;
      19: v = 23'd7;
      20: v = 23'd4;
      21: v = 23'd2;
      22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

  // sideband carried along the rotation cells
  typedef struct packed {
    logic signed [TW-1:0] tl;
    logic signed [TW-1:0] tw;
    logic                 teleop;
    logic [14:0]          scale;
  } rot_side_t;

  // sideband carried along the vectoring cells
  typedef struct packed {
    logic [3:0]  zero;
    logic        teleop;
    logic [14:0] scale;
  } vec_side_t;

  typedef struct packed {
    logic [14:0]        fl_spd;
    logic [14:0]        fr_spd;
    logic [14:0]        bl_spd;
    logic [14:0]        br_spd;
    logic signed [15:0] fl_ang;
    logic signed [15:0] fr_ang;
    logic signed [15:0] bl_ang;
    logic signed [15:0] br_ang;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/swk_cordic_cell.sv
// swk_cordic_cell: one registered cordic micro-rotation, rotation or vectoring
// depends on swk_pkg for the arctangent table
`default_nettype none

module swk_cordic_cell #(
  parameter int STEP = 0,
  parameter bit VEC  = 1'b0,
  parameter int W    = swk_pkg::RW,
  parameter int ZW   = swk_pkg::RZW
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] ATAN =
    $signed({{(ZW-swk_pkg::ATW){1'b0}}, swk_pkg::atan_deg16(STEP)});

  logic signed [W-1:0]  x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 sub;

  always_comb begin
    xs  = x_i >>> STEP;
    ys  = y_i >>> STEP;
    // vectoring drives y to zero, rotation drives z to zero
    sub = VEC ? y_i[W-1] : !z_i[ZW-1];
    if (sub) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

`default_nettype wire

// File: rtl/core/swerve_wheel_kinematics.sv
// swerve_wheel_kinematics: top level, command prep, cordic cell chains, output skid
// depends on swk_pkg and swk_cordic_cell
//
// Swerve drive inverse kinematics. One command item (x, y, turn, heading,
// speed scale, mode) enters and one result item (four wheel speeds in Q1.14,
// four steering angles in 1/128 degree) leaves per clock while unstalled.
// The stages are one prep stage, CORDIC_STEPS rotation cells, a gain stage,
// a swerve term stage, CORDIC_STEPS rows of four vectoring cells, a magnitude
// stage and the output register. The cell chains are fully pipelined, so the
// sustained rate is one item per cycle while out_stall is low. The output
// register is backed by a one-item skid register; in_stall rises only when
// both hold an item. Registers are written through the APB-style port at
// 4*index and should only be changed while no item is in flight.
`default_nettype none

module swerve_wheel_kinematics #(
  parameter int CORDIC_STEPS = swk_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // command items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic signed [15:0] in_turn_rate,
  input  logic signed [15:0] in_heading,
  input  logic [14:0]        in_speed_scale,
  input  logic               in_auto_mode,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic [14:0]        out_front_left_speed,
  output logic [14:0]        out_front_right_speed,
  output logic [14:0]        out_back_left_speed,
  output logic [14:0]        out_back_right_speed,
  output logic signed [15:0] out_front_left_angle,
  output logic signed [15:0] out_front_right_angle,
  output logic signed [15:0] out_back_left_angle,
  output logic signed [15:0] out_back_right_angle,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int N  = CORDIC_STEPS;
  localparam int NS = 2 * N + 4;          // pipeline stages before the output register
  localparam int RW  = swk_pkg::RW;
  localparam int RZW = swk_pkg::RZW;
  localparam int GW  = swk_pkg::GW;
  localparam int PW  = swk_pkg::PW;
  localparam int VW  = swk_pkg::VW;
  localparam int VZW = swk_pkg::VZW;
  localparam int SW  = swk_pkg::SW;

  // ---------------------------------------------------------------- registers
  logic [15:0] len_ratio_r, wid_ratio_r;
  logic [14:0] x_db_r, y_db_r, tpos_db_r, tneg_db_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_ratio_r <= swk_pkg::RATIO_RST;
      wid_ratio_r <= swk_pkg::RATIO_RST;
      x_db_r      <= '0;
      y_db_r      <= '0;
      tpos_db_r   <= '0;
      tneg_db_r   <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        swk_pkg::REG_LENGTH_RATIO: len_ratio_r <= pwdata[15:0];
        swk_pkg::REG_WIDTH_RATIO:  wid_ratio_r <= pwdata[15:0];
        swk_pkg::REG_X_DEADBAND:   x_db_r      <= pwdata[14:0];
        swk_pkg::REG_Y_DEADBAND:   y_db_r      <= pwdata[14:0];
        swk_pkg::REG_TURN_POS_DB:  tpos_db_r   <= pwdata[14:0];
        swk_pkg::REG_TURN_NEG_DB:  tneg_db_r   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      swk_pkg::REG_LENGTH_RATIO: prdata = {16'd0, len_ratio_r};
      swk_pkg::REG_WIDTH_RATIO:  prdata = {16'd0, wid_ratio_r};
      swk_pkg::REG_X_DEADBAND:   prdata = {17'd0, x_db_r};
      swk_pkg::REG_Y_DEADBAND:   prdata = {17'd0, y_db_r};
      swk_pkg::REG_TURN_POS_DB:  prdata = {17'd0, tpos_db_r};
      swk_pkg::REG_TURN_NEG_DB:  prdata = {17'd0, tneg_db_r};
      default:                   prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  // the whole chain moves together while the skid register is empty
  logic          en;
  logic          vld_r [NS];
  logic          out_valid_r, skid_valid_r;
  swk_pkg::result_t out_r, skid_r, res_c;
  logic          take;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign take     = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // ---------------------------------------------------------------- prep stage
  logic signed [17:0] vx18, vy18, tr18, xdb18, ydb18, tpdb18, tndb18;
  logic signed [16:0] vx_d, vy_d;
  logic signed [15:0] tr_d;
  logic signed [17:0] hd, hw, ha;
  logic               flip, teleop_in;
  logic signed [RW-1:0]  xs0, ys0;
  logic signed [40:0]    tlp, twp;
  logic signed [23:0]    t24;

  logic signed [RW-1:0]  rx [N+1];
  logic signed [RW-1:0]  ry [N+1];
  logic signed [RZW-1:0] rz [N+1];
  swk_pkg::rot_side_t    rside_r [N+1];

  always_comb begin
    teleop_in = !in_auto_mode;
    vx18   = 18'(in_vel_x);
    vy18   = -18'(in_vel_y);               // y is negated before anything else
    tr18   = 18'(in_turn_rate);
    xdb18  = $signed({3'd0, x_db_r});
    ydb18  = $signed({3'd0, y_db_r});
    tpdb18 = $signed({3'd0, tpos_db_r});
    tndb18 = $signed({3'd0, tneg_db_r});

    // dead zones are strict on both sides and only apply in teleop
    vx_d = vx18[16:0];
    vy_d = vy18[16:0];
    tr_d = in_turn_rate;
    if (teleop_in) begin
      if ((vx18 < xdb18) && (vx18 > -xdb18)) vx_d = '0;
      if ((vy18 < ydb18) && (vy18 > -ydb18)) vy_d = '0;
      if ((tr18 < tpdb18) && (tr18 > -tndb18)) tr_d = '0;
    end

    // wrap heading to +-180 deg, then fold into +-90 deg by negating the vector
    hd = 18'(in_heading);
    hw = hd;
    if (hd >= swk_pkg::HEAD_HALF) hw = hd - swk_pkg::HEAD_TURN;
    else if (hd < -swk_pkg::HEAD_HALF) hw = hd + swk_pkg::HEAD_TURN;
    flip = 1'b0;
    ha   = hw;
    if (hw > swk_pkg::HEAD_QUARTER) begin
      flip = 1'b1;
      ha   = hw - swk_pkg::HEAD_HALF;
    end else if (hw < -swk_pkg::HEAD_QUARTER) begin
      flip = 1'b1;
      ha   = hw + swk_pkg::HEAD_HALF;
    end

    // the rotation pair is (x, y) = (vy, vx) in q.22
    xs0 = RW'($signed({vy_d, 8'd0}));
    ys0 = RW'($signed({vx_d, 8'd0}));

    // turn terms, t * ratio in q.22
    t24 = $signed({tr_d, 8'd0});
    tlp = 41'(t24) * 41'($signed({1'b0, len_ratio_r}));
    twp = 41'(t24) * 41'($signed({1'b0, wid_ratio_r}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0] <= flip ? -xs0 : xs0;
      ry[0] <= flip ? -ys0 : ys0;
      rz[0] <= RZW'($signed({ha, 9'd0}));
      rside_r[0].tl     <= $signed(tlp[40:16]);
      rside_r[0].tw     <= $signed(twp[40:16]);
      rside_r[0].teleop <= teleop_in;
      rside_r[0].scale  <= in_speed_scale;
    end
  end

  // ---------------------------------------------------------------- rotation chain
  for (genvar k = 1; k <= N; k++) begin : g_rot
    swk_cordic_cell #(
      .STEP (k - 1),
      .VEC  (1'b0),
      .W    (RW),
      .ZW   (RZW)
    ) u_cell (
      .clk (clk),
      .en  (en),
      .x_i (rx[k-1]),
      .y_i (ry[k-1]),
      .z_i (rz[k-1]),
      .x_o (rx[k]),
      .y_o (ry[k]),
      .z_o (rz[k])
    );

    always_ff @(posedge clk) begin
      if (en) rside_r[k] <= rside_r[k-1];
    end
  end

  // ---------------------------------------------------------------- gain stage
  logic signed [RW+16:0] gxp, gyp;
  logic signed [GW-1:0]  gx_r, gy_r;
  swk_pkg::rot_side_t    gside_r;

  always_comb begin
    gxp = (RW+17)'(rx[N]) * (RW+17)'($signed({1'b0, swk_pkg::INV_GAIN}));
    gyp = (RW+17)'(ry[N]) * (RW+17)'($signed({1'b0, swk_pkg::INV_GAIN}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx_r    <= gxp[GW+15:16];
      gy_r    <= gyp[GW+15:16];
      gside_r <= rside_r[N];
    end
  end

  // ---------------------------------------------------------------- swerve terms
  // a = y - tl, b = y + tl, c = x - tw, d = x + tw
  // lanes: front left (b, d), front right (b, c), back left (a, d), back right (a, c)
  logic signed [PW-1:0] ta, tb, tc, td;
  logic signed [PW-1:0] ty_l [4];
  logic signed [PW-1:0] tx_l [4];

  logic signed [VW-1:0]  vxa [N+1][4];
  logic signed [VW-1:0]  vya [N+1][4];
  logic signed [VZW-1:0] vza [N+1][4];
  swk_pkg::vec_side_t    vside_r [N+1];

  always_comb begin
    ta = PW'(gy_r) - PW'(gside_r.tl);
    tb = PW'(gy_r) + PW'(gside_r.tl);
    tc = PW'(gx_r) - PW'(gside_r.tw);
    td = PW'(gx_r) + PW'(gside_r.tw);
    ty_l[0] = tb; tx_l[0] = td;
    ty_l[1] = tb; tx_l[1] = tc;
    ty_l[2] = ta; tx_l[2] = td;
    ty_l[3] = ta; tx_l[3] = tc;
  end

  for (genvar l = 0; l < 4; l++) begin : g_vprep
    logic neg_x;
    assign neg_x = tx_l[l][PW-1];

    // negative x: mirror the pair and start from +-180 deg
    always_ff @(posedge clk) begin
      if (en) begin
        vxa[0][l] <= neg_x ? -VW'(tx_l[l]) : VW'(tx_l[l]);
        vya[0][l] <= neg_x ? -VW'(ty_l[l]) : VW'(ty_l[l]);
        if (!neg_x) vza[0][l] <= '0;
        else if (ty_l[l][PW-1]) vza[0][l] <= -swk_pkg::Z_HALF_TURN;
        else vza[0][l] <= swk_pkg::Z_HALF_TURN;
        vside_r[0].zero[l] <= (tx_l[l] == '0) && (ty_l[l] == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vside_r[0].teleop <= gside_r.teleop;
      vside_r[0].scale  <= gside_r.scale;
    end
  end

  // ---------------------------------------------------------------- vectoring chain
  for (genvar k = 1; k <= N; k++) begin : g_vec
    for (genvar l = 0; l < 4; l++) begin : g_lane
      swk_cordic_cell #(
        .STEP (k - 1),
        .VEC  (1'b1),
        .W    (VW),
        .ZW   (VZW)
      ) u_cell (
        .clk (clk),
        .en  (en),
        .x_i (vxa[k-1][l]),
        .y_i (vya[k-1][l]),
        .z_i (vza[k-1][l]),
        .x_o (vxa[k][l]),
        .y_o (vya[k][l]),
        .z_o (vza[k][l])
      );
    end

    always_ff @(posedge clk) begin
      if (en) vside_r[k] <= vside_r[k-1];
    end
  end

  // ---------------------------------------------------------------- magnitude stage
  logic signed [SW-1:0] spd_r [4];
  logic signed [15:0]   ang_r [4];
  logic                 mteleop_r;
  logic [14:0]          mscale_r;

  for (genvar l = 0; l < 4; l++) begin : g_mag
    logic signed [VW+16:0] mp;
    logic signed [27:0]    mr, zr;
    logic signed [18:0]    ar;
    logic signed [15:0]    ac;

    always_comb begin
      mp = (VW+17)'(vxa[N][l]) * (VW+17)'($signed({1'b0, swk_pkg::INV_GAIN}));
      // magnitude back to q1.14 with rounding
      mr = 28'($signed(mp[42:16])) + 28'sd128;
      // angle to 1/128 deg with rounding, clamped to +-180 deg
      zr = 28'(vza[N][l]) + 28'sd256;
      ar = zr[27:9];
      if (ar > swk_pkg::ANG_MAX) ac = 16'(swk_pkg::ANG_MAX);
      else if (ar < -swk_pkg::ANG_MAX) ac = 16'(-swk_pkg::ANG_MAX);
      else ac = ar[15:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        spd_r[l] <= vside_r[N].zero[l] ? '0 : mr[27:8];
        ang_r[l] <= vside_r[N].zero[l] ? '0 : ac;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mteleop_r <= vside_r[N].teleop;
      mscale_r  <= vside_r[N].scale;
    end
  end

  // ---------------------------------------------------------------- teleop scale, saturation
  logic [14:0] spd_c [4];

  for (genvar l = 0; l < 4; l++) begin : g_sat
    logic signed [35:0] sp;
    logic signed [21:0] sv;

    always_comb begin
      sp = 36'(spd_r[l]) * 36'($signed({1'b0, mscale_r})) + 36'sd8192;
      sv = mteleop_r ? sp[35:14] : 22'(spd_r[l]);
      if (sv[21]) spd_c[l] = '0;
      else if (sv > swk_pkg::SPEED_MAX) spd_c[l] = 15'(swk_pkg::SPEED_MAX);
      else spd_c[l] = sv[14:0];
    end
  end

  always_comb begin
    res_c.fl_spd = spd_c[0];
    res_c.fr_spd = spd_c[1];
    res_c.bl_spd = spd_c[2];
    res_c.br_spd = spd_c[3];
    res_c.fl_ang = ang_r[0];
    res_c.fr_ang = ang_r[1];
    res_c.bl_ang = ang_r[2];
    res_c.br_ang = ang_r[3];
  end

  // ---------------------------------------------------------------- output register and skid
  // a finished item goes to the output register when it is free or being
  // taken, otherwise it parks in the skid register and freezes the chain
  logic out_valid_nxt, skid_valid_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (take) skid_valid_nxt = 1'b0;
    end else if (vld_r[NS-1]) begin
      if (!out_valid_r || take) out_valid_nxt = 1'b1;
      else skid_valid_nxt = 1'b1;
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) out_r <= skid_r;
    end else if (vld_r[NS-1]) begin
      if (!out_valid_r || take) out_r <= res_c;
      else skid_r <= res_c;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_front_left_speed  = out_r.fl_spd;
  assign out_front_right_speed = out_r.fr_spd;
  assign out_back_left_speed   = out_r.bl_spd;
  assign out_back_right_speed  = out_r.br_spd;
  assign out_front_left_angle  = out_r.fl_ang;
  assign out_front_right_angle = out_r.fr_ang;
  assign out_back_left_angle   = out_r.bl_ang;
  assign out_back_right_angle  = out_r.br_ang;

endmodule

`default_nettype wire

// File: rtl/core/swk_checker.sv
// swk_checker: port-level checks for swerve_wheel_kinematics, bound to the top
// depends only on the top level's ports
`default_nettype none

module swk_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [14:0]        out_front_left_speed,
  input logic signed [15:0] out_front_left_angle,
  input logic signed [15:0] out_front_right_angle,
  input logic signed [15:0] out_back_left_angle,
  input logic signed [15:0] out_back_right_angle
);

  // a held item stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // the result side comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item offered right after reset");

  // input only backs up when a result is already waiting at the output
  a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // steering angles stay within +-180 deg
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_front_left_angle >= -16'sd23040) &&
                  (out_front_left_angle <= 16'sd23040) &&
                  (out_front_right_angle >= -16'sd23040) &&
                  (out_front_right_angle <= 16'sd23040) &&
                  (out_back_left_angle >= -16'sd23040) &&
                  (out_back_left_angle <= 16'sd23040) &&
                  (out_back_right_angle >= -16'sd23040) &&
                  (out_back_right_angle <= 16'sd23040))
    else $error("steering angle out of range");

  // a stalled front left speed does not change
  a_hold_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_front_left_speed))
    else $error("stalled result item changed");

endmodule

bind swerve_wheel_kinematics swk_checker u_swk_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_front_left_speed  (out_front_left_speed),
  .out_front_left_angle  (out_front_left_angle),
  .out_front_right_angle (out_front_right_angle),
  .out_back_left_angle   (out_back_left_angle),
  .out_back_right_angle  (out_back_right_angle)
);

`default_nettype wire
